// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by adfs_out_buf and apogee_detect_flight_sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/adfs_pkg.sv =====
package adfs_pkg;

   // Window depth (2 .. 16)
   localparam int Window = 5;

   // Field widths
   localparam int AltW    = 21;
   localparam int HeightW = 20;
   localparam int MinW    = 4;
   localparam int CountW  = 4;
   localparam int PhaseW  = 3;
   localparam int FillW   = $clog2(Window + 1);
   localparam int CsrIdxW = 1;

   typedef logic signed [AltW-1:0] alt_type;
   typedef logic [CountW-1:0]      count_type;
   typedef logic [FillW-1:0]       fill_type;

   // Altitude clamp limits, decimeters
   localparam alt_type AltMin = alt_type'(-100000);
   localparam alt_type AltMax = alt_type'(1000000);

   // Register reset values
   localparam logic [HeightW-1:0] HeightReset = HeightW'(650);
   localparam logic [MinW-1:0]    MinReset    = MinW'(3);

   typedef enum logic [PhaseW-1:0] {
      PH_PRE       = 3'd0,
      PH_ASCENT    = 3'd1,
      PH_CHECK     = 3'd2,
      PH_DESCENT   = 3'd3,
      PH_TOUCHDOWN = 3'd4
   } phase_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_IGN_HEIGHT   = 1'b0,
      CSR_MIN_DESCENTS = 1'b1
   } csr_idx_type;

   // One result transfer
   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic              apogee_detected;
      logic              second_ignition;
      count_type         descending_count;
   } rsp_type;

endpackage

// ===== hdl/adfs_cell.sv =====
module adfs_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  adfs_pkg::alt_type d_in,
   output adfs_pkg::alt_type q,
   output logic              drop
);

   adfs_pkg::alt_type q_ff;

   // Sample storage, loaded from the newer neighbor
   always_ff @(posedge clock) begin
      if (shift_en) begin
         q_ff <= d_in;
      end
   end

   assign q = q_ff;

   // After the shift, d_in sits here and q_ff one place older: a drop if newer is lower
   assign drop = (d_in < q_ff);

endmodule

// ===== hdl/adfs_window.sv =====
module adfs_window (
   input  logic                clock,
   input  logic                shift_en,
   input  adfs_pkg::alt_type   alt_in,
   output adfs_pkg::count_type count
);

   // Cell k holds window entry k; the oldest entry is compared on the tick it leaves
   adfs_pkg::alt_type tap  [1:adfs_pkg::Window-1];
   adfs_pkg::alt_type feed [1:adfs_pkg::Window-1];
   logic [adfs_pkg::Window-1:1] drop;

   // Newest sample enters at the tail, each cell takes from its right neighbor
   assign feed[adfs_pkg::Window-1] = alt_in;

   for (genvar k = 1; k < adfs_pkg::Window - 1; k++) begin : g_feed
      assign feed[k] = tap[k+1];
   end

   for (genvar k = 1; k < adfs_pkg::Window; k++) begin : g_cell
      adfs_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d_in     (feed[k]),
         .q        (tap[k]),
         .drop     (drop[k])
      );
   end

   // Population count of the drop flags
   always_comb begin
      count = '0;
      for (int k = 1; k < adfs_pkg::Window; k++) begin
         count = count + adfs_pkg::count_type'(drop[k]);
      end
   end

endmodule

// ===== hdl/adfs_out_buf.sv =====
`include "assert_macros.svh"

module adfs_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  adfs_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output adfs_pkg::rsp_type out_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   adfs_pkg::rsp_type rsp_ff, rsp_in;
   adfs_pkg::rsp_type skid_ff, skid_in;
   logic              in_xfer;

   assign in_stall = skid_valid_ff;
   assign in_xfer  = in_valid && !skid_valid_ff;

   // Main register drains to the port, skid catches a transfer while it is stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (in_xfer) begin
            rsp_in       = in_data;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (in_xfer) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   // Skid only fills behind an occupied main register
   `ASSERT_IMPLIES(a_skid_behind_main, clock, reset, skid_valid_ff, rsp_valid_ff, "skid full with main empty")

endmodule

// ===== hdl/apogee_detect_flight_sequencer.sv =====
// Each result is registered in the output buffer: in its main register, or in its skid register under output stall.
// Throughput: one item per cycle while the input is not stalled; the window compare and drop count are combinational.
// A two-entry output buffer takes one more input transfer once the output stalls, then stalls the input.
// Synchronous reset: phase to pre-ignition, fill count to zero, registers to 650 and 3.
// Window samples are not cleared; they are read only once the window has filled.
`include "assert_macros.svh"

module apogee_detect_flight_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_ignitable,
   input  adfs_pkg::alt_type                   req_altitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [adfs_pkg::PhaseW-1:0]         rsp_phase,
   output logic                                rsp_apogee_detected,
   output logic                                rsp_second_ignition,
   output logic [adfs_pkg::CountW-1:0]         rsp_descending_count,
   input  logic                                csr_wen,
   input  logic [adfs_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [adfs_pkg::HeightW-1:0]        csr_wdata
);

   adfs_pkg::phase_type          phase_ff, phase_in;
   adfs_pkg::fill_type           fill_ff, fill_in;
   logic [adfs_pkg::HeightW-1:0] height_ff;
   logic [adfs_pkg::MinW-1:0]    min_ff;

   adfs_pkg::alt_type   alt_sat;
   adfs_pkg::count_type win_count;
   adfs_pkg::rsp_type   result;
   logic                req_xfer;
   logic                shift_en;
   logic                full_now;

   assign req_xfer = req_valid && !req_stall;

   // Clamp altitude to its legal range
   always_comb begin
      priority if (req_altitude < adfs_pkg::AltMin) begin
         alt_sat = adfs_pkg::AltMin;
      end else if (req_altitude > adfs_pkg::AltMax) begin
         alt_sat = adfs_pkg::AltMax;
      end else begin
         alt_sat = req_altitude;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= adfs_pkg::HeightReset;
         min_ff    <= adfs_pkg::MinReset;
      end else if (csr_wen) begin
         unique case (adfs_pkg::csr_idx_type'(csr_index))
            adfs_pkg::CSR_IGN_HEIGHT:   height_ff <= csr_wdata;
            adfs_pkg::CSR_MIN_DESCENTS: min_ff    <= csr_wdata[adfs_pkg::MinW-1:0];
         endcase
      end
   end

   // Sample window, shifted on every ascent transfer
   assign shift_en = req_xfer && (phase_ff == adfs_pkg::PH_ASCENT);
   assign full_now = (fill_ff >= adfs_pkg::fill_type'(adfs_pkg::Window - 1));

   adfs_window u_window (
      .clock    (clock),
      .shift_en (shift_en),
      .alt_in   (alt_sat),
      .count    (win_count)
   );

   // Phase sequencing and result fields
   always_comb begin
      phase_in = phase_ff;
      fill_in  = fill_ff;
      result   = '0;
      unique case (phase_ff)
         adfs_pkg::PH_PRE: begin
            if (req_ignitable) begin
               phase_in = adfs_pkg::PH_ASCENT;
            end
         end
         adfs_pkg::PH_ASCENT: begin
            if (fill_ff < adfs_pkg::fill_type'(adfs_pkg::Window)) begin
               fill_in = fill_ff + adfs_pkg::fill_type'(1);
            end
            if (full_now) begin
               result.descending_count = win_count;
               if (win_count >= adfs_pkg::count_type'(min_ff)) begin
                  result.apogee_detected = 1'b1;
                  phase_in = adfs_pkg::PH_CHECK;
               end
            end
         end
         adfs_pkg::PH_CHECK: begin
            result.second_ignition = (alt_sat <= adfs_pkg::alt_type'({1'b0, height_ff}));
            phase_in = adfs_pkg::PH_DESCENT;
         end
         adfs_pkg::PH_DESCENT: begin
            phase_in = adfs_pkg::PH_TOUCHDOWN;
         end
         adfs_pkg::PH_TOUCHDOWN: begin
            phase_in = phase_ff;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      result.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= adfs_pkg::PH_PRE;
         fill_ff  <= '0;
      end else if (req_xfer) begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
      end
   end

   // Result buffer
   adfs_pkg::rsp_type rsp_data;

   adfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_phase            = rsp_data.phase;
   assign rsp_apogee_detected  = rsp_data.apogee_detected;
   assign rsp_second_ignition  = rsp_data.second_ignition;
   assign rsp_descending_count = rsp_data.descending_count;

   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= adfs_pkg::fill_type'(adfs_pkg::Window), "fill count past window depth")
   `ASSERT_NEXT(a_touchdown_holds, clock, reset, phase_ff == adfs_pkg::PH_TOUCHDOWN, phase_ff == adfs_pkg::PH_TOUCHDOWN, "left touchdown")
   `ASSERT_NEXT(a_check_after_full, clock, reset, phase_ff != adfs_pkg::PH_CHECK, phase_ff != adfs_pkg::PH_CHECK || $past(full_now), "apogee before window full")

endmodule

// ===== test/apogee_detect_flight_sequencer_tb.sv =====
module apogee_detect_flight_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import adfs_pkg::*;

   localparam int QuietLimit    = 2000;
   localparam int DrainCycles   = 4;
   localparam int AscentBatches = 8;
   localparam int BatchLen      = 48;

   typedef struct {
      logic    ignitable;
      alt_type altitude;
   } tick_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_ignitable = 1'b0;
   alt_type             req_altitude = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PhaseW-1:0]   rsp_phase;
   logic                rsp_apogee_detected;
   logic                rsp_second_ignition;
   logic [CountW-1:0]   rsp_descending_count;
   logic                csr_wen = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [HeightW-1:0]  csr_wdata = '0;

   apogee_detect_flight_sequencer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ignitable        (req_ignitable),
      .req_altitude         (req_altitude),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_phase            (rsp_phase),
      .rsp_apogee_detected  (rsp_apogee_detected),
      .rsp_second_ignition  (rsp_second_ignition),
      .rsp_descending_count (rsp_descending_count),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Sensor ticks waiting to be sent, and reports still owed by the block
   tick_type pending_ticks[$];
   rsp_type  expected_reports[$];

   int errors = 0;
   int gap_odds = 0;
   int stall_odds = 0;
   int gap_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int walk = 0;
   int trend = 1;

   // Flight state mirror
   phase_type          flight_phase_q;
   alt_type            window_q[Window];
   int                 fill_q;
   logic [HeightW-1:0] height_cfg;
   logic [MinW-1:0]    min_cfg;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic alt_type clamp_altitude(alt_type raw);
      if (raw < AltMin) return AltMin;
      if (raw > AltMax) return AltMax;
      return raw;
   endfunction

   // Advance the flight mirror by one tick and return the report it owes
   function automatic rsp_type flight_step(tick_type t);
      rsp_type r;
      alt_type a;
      int      drops;
      r = '0;
      drops = 0;
      a = clamp_altitude(t.altitude);
      case (flight_phase_q)
         PH_PRE: begin
            if (t.ignitable) flight_phase_q = PH_ASCENT;
         end
         PH_ASCENT: begin
            if (fill_q < Window) begin
               window_q[fill_q] = a;
               fill_q++;
            end else begin
               for (int i = 0; i < Window - 1; i++) window_q[i] = window_q[i+1];
               window_q[Window-1] = a;
            end
            // full window: count falling neighbor pairs
            if (fill_q >= Window) begin
               for (int i = 0; i < Window - 1; i++)
                  if (window_q[i+1] < window_q[i]) drops++;
               if (drops >= int'(min_cfg)) begin
                  r.apogee_detected = 1'b1;
                  flight_phase_q = PH_CHECK;
               end
            end
         end
         PH_CHECK: begin
            if (int'(a) <= int'(height_cfg)) r.second_ignition = 1'b1;
            flight_phase_q = PH_DESCENT;
         end
         PH_DESCENT: begin
            flight_phase_q = PH_TOUCHDOWN;
         end
         default: ;
      endcase
      r.phase = flight_phase_q;
      r.descending_count = count_type'(drops);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Request driver: holds a stalled transfer, inserts gap bursts
   always @(posedge clock) begin
      tick_type sent;
      tick_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            sent.ignitable = req_ignitable;
            sent.altitude = req_altitude;
            expected_reports.push_back(flight_step(sent));
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if ($urandom_range(1, 100) <= gap_odds) begin
            gap_left = $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            nxt = pending_ticks.pop_front();
            req_valid <= 1'b1;
            req_ignitable <= nxt.ignitable;
            req_altitude <= nxt.altitude;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Report monitor and stall bursts
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report: expected none, actual phase %0d apogee %0b",
                        $time, rsp_phase, rsp_apogee_detected);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("phase", want.phase, rsp_phase);
               check_field("apogee_detected", want.apogee_detected, rsp_apogee_detected);
               check_field("second_ignition", want.second_ignition, rsp_second_ignition);
               check_field("descending_count", want.descending_count, rsp_descending_count);
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(1, 100) <= stall_odds) begin
            stall_left = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("apogee_detect_flight_sequencer test failed");
            $finish;
         end
      end
   end

   task automatic add_tick(logic ign, int alt);
      tick_type t;
      t.ignitable = ign;
      t.altitude = alt_type'(alt);
      pending_ticks.push_back(t);
   endtask

   // Wait until every tick is sent and every report is back
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_ticks.size() != 0 || req_valid || expected_reports.size() != 0);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [HeightW-1:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_IGN_HEIGHT) height_cfg = data;
      else min_cfg = data[MinW-1:0];
   endtask

   // Altitude track: mostly a drifting climb or fall, some raw and extreme samples
   task automatic queue_flight_samples(int count);
      int alt;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 15))
            0: alt = int'(alt_type'($urandom()));
            1: begin
               case ($urandom_range(0, 5))
                  0: alt = -1048576;
                  1: alt = 1048575;
                  2: alt = int'(AltMin) - 1;
                  3: alt = int'(AltMax) + 1;
                  4: alt = int'(AltMin);
                  default: alt = int'(AltMax);
               endcase
            end
            default: begin
               if ($urandom_range(0, 7) == 0) trend = int'($urandom_range(0, 2)) - 1;
               walk += trend * int'($urandom_range(0, 500)) + int'($urandom_range(0, 40)) - 20;
               if (walk < int'(AltMin)) walk = int'(AltMin);
               if (walk > int'(AltMax)) walk = int'(AltMax);
               alt = walk;
            end
         endcase
         add_tick($urandom_range(0, 1), alt);
      end
   endtask

   initial begin
      logic [HeightW-1:0] wdata;
      int                 height;
      flight_phase_q = PH_PRE;
      fill_q = 0;
      height_cfg = HeightReset;
      min_cfg = MinReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Pre-ignition: altitude is ignored without the ignitable flag
      add_tick(1'b0, 0);
      add_tick(1'b0, -1048576);
      add_tick(1'b0, 1048575);
      add_tick(1'b0, -1);
      wait_idle();
      // min_descents above any possible count keeps the ascent going
      csr_write(CSR_MIN_DESCENTS, '1);
      csr_write(CSR_IGN_HEIGHT, '1);

      // Ignition, then window fill with saturating samples
      add_tick(1'b1, 500);
      add_tick(1'b0, 1000001);
      add_tick(1'b1, 1048575);
      add_tick(1'b0, -100001);
      add_tick(1'b1, -1048576);
      add_tick(1'b0, 0);
      add_tick(1'b0, 1000000);
      add_tick(1'b1, -100000);
      add_tick(1'b0, -100000);
      add_tick(1'b0, -99999);
      // strictly falling run, then a flat run
      for (int i = 4; i >= 0; i--) add_tick(1'b0, i * 10);
      for (int i = 0; i < 5; i++) add_tick(1'b1, 7);
      wait_idle();
      csr_write(CSR_IGN_HEIGHT, '0);

      // Random ascent with varying idle pressure and non-firing thresholds
      for (int b = 0; b < AscentBatches; b++) begin
         case (b % 4)
            0: begin gap_odds = 0;  stall_odds = 0;  end
            1: begin gap_odds = 10; stall_odds = 10; end
            2: begin gap_odds = 30; stall_odds = 5;  end
            default: begin gap_odds = 5; stall_odds = 40; end
         endcase
         wdata = HeightW'($urandom());
         wdata[MinW-1:0] = MinW'($urandom_range(Window, 15));
         csr_write(CSR_MIN_DESCENTS, wdata);
         csr_write(CSR_IGN_HEIGHT, (b == 1) ? HeightW'(1000000) : HeightW'($urandom_range(0, 1000000)));
         queue_flight_samples(BatchLen);
         wait_idle();
      end

      // Apogee: low threshold, then a falling track one tick at a time
      csr_write(CSR_MIN_DESCENTS, $urandom_range(0, 1) ? '0 : HeightW'($urandom_range(1, 4)));
      gap_odds = 15;
      stall_odds = 15;
      walk = $urandom_range(500000, 1000000);
      while (flight_phase_q == PH_ASCENT) begin
         walk -= int'($urandom_range(1, 300));
         add_tick($urandom_range(0, 1), walk);
         wait_idle();
      end

      // Check tick at, just below or just above the second ignition height
      case ($urandom_range(0, 2))
         0: height = 0;
         1: height = 1000000;
         default: height = $urandom_range(0, 1000000);
      endcase
      csr_write(CSR_IGN_HEIGHT, HeightW'(height));
      add_tick($urandom_range(0, 1), height + int'($urandom_range(0, 2)) - 1);

      // Descent and touchdown without idling
      gap_odds = 0;
      stall_odds = 0;
      queue_flight_samples(40);
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("apogee_detect_flight_sequencer test passed");
      end else begin
         $display("apogee_detect_flight_sequencer test failed");
      end
      $finish;
   end

endmodule
